[rtl/hbs_pkg.sv]
package hbs_pkg;

    localparam int GRID_MAX    = 256;
    localparam int STORE_CELLS = GRID_MAX * GRID_MAX;
    localparam int ADDR_W      = $clog2(STORE_CELLS);
    localparam int SIDE_W      = $clog2(GRID_MAX + 1);
    localparam int SC_W        = $clog2(GRID_MAX);
    localparam int F_W         = SC_W + 16;
    localparam int DCNT_W      = $clog2(F_W + 1);

    localparam int H_W     = 32;
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 18;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int M_W     = 49;
    localparam int Q_W     = 34;
    localparam int T_W     = 17;
    localparam int SAT_W   = 37;

    localparam logic [8:0]         SAMPLE_COUNT_RST = 9'd256;
    localparam logic [30:0]        WORLD_SIZE_RST   = 31'd65536;
    localparam logic signed [31:0] MIN_HEIGHT_RST   = 32'sd0;
    localparam logic signed [31:0] MAX_HEIGHT_RST   = 32'sd65536;

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_RAW   = 2'd1,
        REQ_QUERY = 2'd2
    } req_t;

    typedef enum logic [1:0] {
        CFG_SAMPLE_COUNT = 2'd0,
        CFG_WORLD_SIZE   = 2'd1,
        CFG_MIN_HEIGHT   = 2'd2,
        CFG_MAX_HEIGHT   = 2'd3
    } cfg_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_W_SQ,
        ST_W_CHK,
        ST_R_MUL,
        ST_R_SGN,
        ST_R_DIV,
        ST_R_WR,
        ST_Q_AX,
        ST_Q_DINIT,
        ST_Q_DIV,
        ST_Q_ADDR,
        ST_Q_BASE,
        ST_Q_RD0,
        ST_Q_RD1,
        ST_Q_RD2,
        ST_Q_RD3,
        ST_Q_LA,
        ST_Q_LB,
        ST_Q_LC,
        ST_Q_LD,
        ST_Q_LE
    } state_t;

endpackage

[rtl/hbs_ram.sv]
module hbs_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH = 256,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/heightmap_bilinear_sampler_top.sv]
// heightmap sampler: a square grid of signed Q16.16 heights with bilinear lookup
// items enter on in_valid/in_ready; req_type selects a direct height write,
// a raw 16-bit sample write or a query; only a query gives a result item on
// out_valid/out_ready carrying sampled_height
// registers are written on cfg_valid/cfg_ready with cfg_index and cfg_data
// after reset a clearing pass zeroes the 65536-entry height store, one entry
// a cycle, and in_ready stays low until it ends; register writes are taken
// during that pass
// one item at a time: a direct write takes a square step and a check step; a raw
// write adds a multiply, a sign step, the digit-sum divide by 65535 and a store write
// in a query the restoring divider makes one quotient bit a cycle, 24 per
// axis that falls inside the grid; the three blends share one 34x18
// multiplier, and the four store reads share the single read port
// in_ready returns the cycle after an item finishes; a result waits in an
// output register, so a stalled receiver only holds up the end of a later query
module heightmap_bilinear_sampler_top
    import hbs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         req_type,
    input  logic [15:0]        cell_index,
    input  logic signed [31:0] height_value,
    input  logic [15:0]        raw_sample,
    input  logic signed [31:0] world_x,
    input  logic signed [31:0] world_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] sampled_height,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    function automatic logic signed [H_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
        logic signed [H_W-1:0] r;
        if (v[SAT_W-1:H_W-1] == '0 || v[SAT_W-1:H_W-1] == '1)
        begin
            r = v[H_W-1:0];
        end
        else if (v[SAT_W-1])
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

    function automatic logic signed [H_W-1:0] lerp_end(
        input logic signed [H_W-1:0]    a,
        input logic signed [PROD_W-1:0] pr
    );
        logic signed [PROD_W-1:0]  s;
        logic signed [PROD_W-17:0] q;
        logic signed [SAT_W-1:0]   sum;
        s   = pr + $signed(PROD_W'(32768));
        q   = s[PROD_W-1:16];
        sum = SAT_W'(a) + SAT_W'(q);
        return sat32(sum);
    endfunction

    // control
    state_t              state_reg, state_next;
    logic                out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]   clr_cnt_reg;
    logic                axis_reg, axis_next;
    logic [DCNT_W-1:0]   div_cnt_reg, div_cnt_next;

    // configuration
    logic [8:0]          sample_count_reg;
    logic [30:0]         world_size_reg;
    logic signed [31:0]  min_height_reg;
    logic signed [31:0]  max_height_reg;

    // latched item
    req_t                req_reg;
    logic [15:0]         cell_reg;
    logic signed [31:0]  height_reg;
    logic [15:0]         raw_reg;
    logic signed [31:0]  x_reg;
    logic signed [31:0]  z_reg;

    // datapath
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic [M_W-1:0]      m_reg, m_next;
    logic [Q_W-1:0]      q_reg, q_next;
    logic                neg_reg, neg_next;
    logic [31:0]         rem_reg, rem_next;
    logic [F_W-1:0]      num_reg, num_next;
    logic [F_W-1:0]      fq_reg, fq_next;
    logic [F_W-1:0]      fx_reg, fx_next;
    logic [F_W-1:0]      fz_reg, fz_next;
    logic [SC_W-1:0]     x0_reg, x0_next;
    logic [T_W-1:0]      tx_reg, tx_next;
    logic [T_W-1:0]      tz_reg, tz_next;
    logic [ADDR_W-1:0]   base_reg, base_next;
    logic signed [31:0]  h00_reg, h00_next;
    logic signed [31:0]  h01_reg, h01_next;
    logic signed [31:0]  h10_reg, h10_next;
    logic signed [31:0]  h11_reg, h11_next;
    logic signed [31:0]  top_reg, top_next;
    logic signed [31:0]  bot_reg, bot_next;
    logic signed [31:0]  sampled_height_reg, sampled_height_next;

    // combinational
    logic                in_accept;
    logic [SIDE_W-1:0]   side;
    logic [SIDE_W-1:0]   side_m1;
    logic [SIDE_W-1:0]   side_m2;
    logic [30:0]         ws;
    logic [31:0]         span;
    logic signed [31:0]  pos;
    logic signed [33:0]  p;
    logic                p_low;
    logic                p_high;
    logic [F_W-1:0]      f_edge;
    logic [32:0]         rem2;
    logic                rem_ge;
    logic [F_W-1:0]      f_div;
    logic [SC_W-1:0]     xi;
    logic [SC_W-1:0]     zi;
    logic [SC_W-1:0]     x0;
    logic [SC_W-1:0]     z0;
    logic                cell_ok;
    logic signed [32:0]  range_w;
    logic signed [PROD_W-1:0] mag;
    logic [32:0]         m_hi;
    logic signed [34:0]  q_signed;
    logic signed [31:0]  raw_height;
    logic signed [31:0]  lerp_a;
    logic signed [31:0]  lerp_b;
    logic [T_W-1:0]      lerp_t;
    logic signed [32:0]  lerp_d;
    logic signed [31:0]  blend;
    logic                out_free;

    logic                       mul_en;
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;

    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [31:0]         wr_data;
    logic [ADDR_W-1:0]   rd_addr;
    logic [31:0]         rd_data;

    hbs_ram #(
        .DATA_W (H_W),
        .DEPTH  (STORE_CELLS)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign in_ready       = (state_reg == ST_IDLE);
    assign in_accept      = in_valid && in_ready;
    assign cfg_ready      = (state_reg == ST_IDLE) || (state_reg == ST_CLEAR);
    assign out_valid      = out_valid_reg;
    assign sampled_height = sampled_height_reg;
    assign out_free       = !out_valid_reg || out_ready;

    // side in use, clamped to the store
    always_comb
    begin
        if (sample_count_reg < 9'd2)
        begin
            side = SIDE_W'(2);
        end
        else if (32'(sample_count_reg) > GRID_MAX)
        begin
            side = SIDE_W'(GRID_MAX);
        end
        else
        begin
            side = SIDE_W'(sample_count_reg);
        end
    end

    assign side_m1 = side - SIDE_W'(1);
    assign side_m2 = side - SIDE_W'(2);
    assign ws      = (world_size_reg == '0) ? 31'd1 : world_size_reg;
    assign span    = {ws, 1'b0};

    // axis position against the span
    assign pos    = axis_reg ? z_reg : x_reg;
    assign p      = $signed({pos[31], pos, 1'b0}) + $signed({3'b000, ws});
    assign p_low  = p[33] || (p == '0);
    assign p_high = !p[33] && (p >= $signed({2'b00, span}));
    assign f_edge = p_low ? '0 : {side_m1[SC_W-1:0], 16'h0000};

    // restoring divider step
    assign rem2   = {rem_reg, num_reg[F_W-1]};
    assign rem_ge = (rem2 >= {1'b0, span});
    assign f_div  = {fq_reg[F_W-2:0], rem_ge};

    // base cell
    assign xi = fx_reg[F_W-1:16];
    assign zi = fz_reg[F_W-1:16];
    assign x0 = (SIDE_W'(xi) > side_m2) ? SC_W'(side_m2) : xi;
    assign z0 = (SIDE_W'(zi) > side_m2) ? SC_W'(side_m2) : zi;

    // raw write arithmetic
    assign cell_ok  = (PROD_W'(cell_reg) < prod_reg);
    assign range_w  = $signed({max_height_reg[31], max_height_reg})
                    - $signed({min_height_reg[31], min_height_reg});
    assign mag      = prod_reg[PROD_W-1] ? -prod_reg : prod_reg;
    assign m_hi     = m_reg[M_W-1:16];
    assign q_signed = neg_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});
    assign raw_height = sat32(SAT_W'(min_height_reg) + SAT_W'(q_signed));

    // blend operands
    always_comb
    begin
        case (state_reg)
            ST_Q_LB, ST_Q_LC:
            begin
                lerp_a = h10_reg;
                lerp_b = h11_reg;
                lerp_t = tx_reg;
            end
            ST_Q_LD, ST_Q_LE:
            begin
                lerp_a = top_reg;
                lerp_b = bot_reg;
                lerp_t = tz_reg;
            end
            default:
            begin
                lerp_a = h00_reg;
                lerp_b = h01_reg;
                lerp_t = tx_reg;
            end
        endcase
    end

    assign lerp_d    = $signed({lerp_b[31], lerp_b}) - $signed({lerp_a[31], lerp_a});
    assign blend     = lerp_end(lerp_a, prod_reg);
    assign prod_next = mul_a * mul_b;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    case (req_t'(req_type))
                        REQ_WRITE, REQ_RAW: state_next = ST_W_SQ;
                        REQ_QUERY:          state_next = ST_Q_AX;
                        default:            state_next = ST_IDLE;
                    endcase
                end
            end
            ST_W_SQ:
            begin
                state_next = ST_W_CHK;
            end
            ST_W_CHK:
            begin
                if (cell_ok && req_reg == REQ_RAW)
                begin
                    state_next = ST_R_MUL;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_R_MUL:
            begin
                state_next = ST_R_SGN;
            end
            ST_R_SGN:
            begin
                state_next = ST_R_DIV;
            end
            ST_R_DIV:
            begin
                if (m_hi == '0)
                begin
                    state_next = ST_R_WR;
                end
            end
            ST_R_WR:
            begin
                state_next = ST_IDLE;
            end
            ST_Q_AX:
            begin
                if (p_low || p_high)
                begin
                    state_next = axis_reg ? ST_Q_ADDR : ST_Q_AX;
                end
                else
                begin
                    state_next = ST_Q_DINIT;
                end
            end
            ST_Q_DINIT:
            begin
                state_next = ST_Q_DIV;
            end
            ST_Q_DIV:
            begin
                if (div_cnt_reg == DCNT_W'(1))
                begin
                    state_next = axis_reg ? ST_Q_ADDR : ST_Q_AX;
                end
            end
            ST_Q_ADDR: state_next = ST_Q_BASE;
            ST_Q_BASE: state_next = ST_Q_RD0;
            ST_Q_RD0:  state_next = ST_Q_RD1;
            ST_Q_RD1:  state_next = ST_Q_RD2;
            ST_Q_RD2:  state_next = ST_Q_RD3;
            ST_Q_RD3:  state_next = ST_Q_LA;
            ST_Q_LA:   state_next = ST_Q_LB;
            ST_Q_LB:   state_next = ST_Q_LC;
            ST_Q_LC:   state_next = ST_Q_LD;
            ST_Q_LD:   state_next = ST_Q_LE;
            ST_Q_LE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and store access
    always_comb
    begin
        out_valid_next      = out_valid_reg && !out_ready;
        axis_next           = axis_reg;
        div_cnt_next        = div_cnt_reg;
        m_next              = m_reg;
        q_next              = q_reg;
        neg_next            = neg_reg;
        rem_next            = rem_reg;
        num_next            = num_reg;
        fq_next             = fq_reg;
        fx_next             = fx_reg;
        fz_next             = fz_reg;
        x0_next             = x0_reg;
        tx_next             = tx_reg;
        tz_next             = tz_reg;
        base_next           = base_reg;
        h00_next            = h00_reg;
        h01_next            = h01_reg;
        h10_next            = h10_reg;
        h11_next            = h11_reg;
        top_next            = top_reg;
        bot_next            = bot_reg;
        sampled_height_next = sampled_height_reg;
        mul_en              = 1'b0;
        mul_a               = MUL_A_W'(lerp_d);
        mul_b               = MUL_B_W'(lerp_t);
        wr_en               = 1'b0;
        wr_addr             = ADDR_W'(cell_reg);
        wr_data             = height_reg;
        rd_addr             = base_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_cnt_reg;
                wr_data = '0;
            end
            ST_IDLE:
            begin
                axis_next = 1'b0;
            end
            ST_W_SQ:
            begin
                mul_en = 1'b1;
                mul_a  = MUL_A_W'(side);
                mul_b  = MUL_B_W'(side);
            end
            ST_W_CHK:
            begin
                wr_en = cell_ok && (req_reg == REQ_WRITE);
            end
            ST_R_MUL:
            begin
                mul_en = 1'b1;
                mul_a  = MUL_A_W'(range_w);
                mul_b  = MUL_B_W'(raw_reg);
            end
            ST_R_SGN:
            begin
                neg_next = prod_reg[PROD_W-1];
                m_next   = mag[M_W-1:0] + M_W'(32767);
                q_next   = '0;
            end
            ST_R_DIV:
            begin
                // x = 65536a + b = 65535a + (a + b)
                if (m_hi == '0)
                begin
                    if (m_reg[15:0] == 16'hFFFF)
                    begin
                        q_next = q_reg + Q_W'(1);
                    end
                end
                else
                begin
                    q_next = q_reg + Q_W'(m_hi);
                    m_next = M_W'(m_hi) + M_W'(m_reg[15:0]);
                end
            end
            ST_R_WR:
            begin
                wr_en   = 1'b1;
                wr_data = raw_height;
            end
            ST_Q_AX:
            begin
                if (p_low || p_high)
                begin
                    axis_next = !axis_reg;
                    if (axis_reg)
                    begin
                        fz_next = f_edge;
                    end
                    else
                    begin
                        fx_next = f_edge;
                    end
                end
                else
                begin
                    mul_en = 1'b1;
                    mul_a  = p;
                    mul_b  = MUL_B_W'(side_m1);
                end
            end
            ST_Q_DINIT:
            begin
                rem_next     = prod_reg[SC_W +: 32];
                num_next     = {prod_reg[SC_W-1:0], 16'h0000};
                div_cnt_next = DCNT_W'(F_W);
            end
            ST_Q_DIV:
            begin
                rem_next     = rem_ge ? 32'(rem2 - {1'b0, span}) : rem2[31:0];
                num_next     = {num_reg[F_W-2:0], 1'b0};
                fq_next      = f_div;
                div_cnt_next = div_cnt_reg - DCNT_W'(1);
                if (div_cnt_reg == DCNT_W'(1))
                begin
                    axis_next = !axis_reg;
                    if (axis_reg)
                    begin
                        fz_next = f_div;
                    end
                    else
                    begin
                        fx_next = f_div;
                    end
                end
            end
            ST_Q_ADDR:
            begin
                x0_next = x0;
                tx_next = T_W'(fx_reg - {x0, 16'h0000});
                tz_next = T_W'(fz_reg - {z0, 16'h0000});
                mul_en  = 1'b1;
                mul_a   = MUL_A_W'(z0);
                mul_b   = MUL_B_W'(side);
            end
            ST_Q_BASE:
            begin
                base_next = ADDR_W'(prod_reg) + ADDR_W'(x0_reg);
            end
            ST_Q_RD0:
            begin
                rd_addr = base_reg;
            end
            ST_Q_RD1:
            begin
                rd_addr  = base_reg + ADDR_W'(1);
                h00_next = rd_data;
            end
            ST_Q_RD2:
            begin
                rd_addr  = base_reg + ADDR_W'(side);
                h01_next = rd_data;
            end
            ST_Q_RD3:
            begin
                rd_addr  = base_reg + ADDR_W'(side) + ADDR_W'(1);
                h10_next = rd_data;
            end
            ST_Q_LA:
            begin
                h11_next = rd_data;
                mul_en   = 1'b1;
            end
            ST_Q_LB:
            begin
                top_next = lerp_end(h00_reg, prod_reg);
                mul_en   = 1'b1;
            end
            ST_Q_LC:
            begin
                bot_next = blend;
            end
            ST_Q_LD:
            begin
                mul_en = 1'b1;
            end
            ST_Q_LE:
            begin
                if (out_free)
                begin
                    sampled_height_next = blend;
                    out_valid_next      = 1'b1;
                end
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
            clr_cnt_reg   <= '0;
            axis_reg      <= 1'b0;
            div_cnt_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            axis_reg      <= axis_next;
            div_cnt_reg   <= div_cnt_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            end
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_count_reg <= SAMPLE_COUNT_RST;
            world_size_reg   <= WORLD_SIZE_RST;
            min_height_reg   <= MIN_HEIGHT_RST;
            max_height_reg   <= MAX_HEIGHT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_t'(cfg_index))
                CFG_SAMPLE_COUNT: sample_count_reg <= cfg_data[8:0];
                CFG_WORLD_SIZE:   world_size_reg   <= cfg_data[30:0];
                CFG_MIN_HEIGHT:   min_height_reg   <= cfg_data;
                CFG_MAX_HEIGHT:   max_height_reg   <= cfg_data;
                default:          world_size_reg   <= world_size_reg;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            req_reg    <= req_t'(req_type);
            cell_reg   <= cell_index;
            height_reg <= height_value;
            raw_reg    <= raw_sample;
            x_reg      <= world_x;
            z_reg      <= world_z;
        end
        if (mul_en)
        begin
            prod_reg <= prod_next;
        end
        m_reg              <= m_next;
        q_reg              <= q_next;
        neg_reg            <= neg_next;
        rem_reg            <= rem_next;
        num_reg            <= num_next;
        fq_reg             <= fq_next;
        fx_reg             <= fx_next;
        fz_reg             <= fz_next;
        x0_reg             <= x0_next;
        tx_reg             <= tx_next;
        tz_reg             <= tz_next;
        base_reg           <= base_next;
        h00_reg            <= h00_next;
        h01_reg            <= h01_next;
        h10_reg            <= h10_next;
        h11_reg            <= h11_next;
        top_reg            <= top_next;
        bot_reg            <= bot_next;
        sampled_height_reg <= sampled_height_next;
    end

    // store is written only by the clearing pass and the two write kinds
    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == ST_CLEAR || state_reg == ST_W_CHK || state_reg == ST_R_WR))
        else $error("store written outside a write step");

    // divider remainder never reaches the span
    a_rem_below_span: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_Q_DIV) |-> (rem_reg < span))
        else $error("divider remainder out of range");

    // a result item only follows the last blend
    a_out_from_blend: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_Q_LE))
        else $error("result item without a finished query");

    // blend weights stay within one cell
    a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_Q_BASE) |-> (tx_reg <= 17'h10000 && tz_reg <= 17'h10000))
        else $error("blend weight above one");

endmodule
